>>> src/cwt_pkg.sv
// Shared types, widths and calibration tables for the count-to-temperature converter.
`default_nettype none

package cwt_pkg;

    // Field widths
    localparam int COUNT_W   = 16;
    localparam int FQ_W      = 19;
    localparam int SEG_OUT_W = 3;
    localparam int SEG_W     = 4;
    localparam int TEMP_W    = 20;
    localparam int BAR_W     = 4;

    // Parameter defaults
    localparam int WINDOW_LEN_DEF    = 10;
    localparam int SEGMENT_COUNT_DEF = 6;

    // Shared multiplier geometry
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // sum*256/500 == sum*64/125 == (sum * RECIP) >> RECIP_SHIFT for sum < 2**22
    localparam int RECIP_SHIFT = 29;
    localparam logic signed [MUL_A_W-1:0] RECIP = 40'sd274877907;

    // Limits and step sizes
    localparam int FREQ_MAX  = 524287;
    localparam int TEMP_MAX  = 524287;
    localparam int TEMP_MIN  = -524288;
    localparam int SEG_STEP  = 2560;
    localparam int BAR_STEP  = 2560;
    localparam int BAR_MAX   = 12;
    localparam int COEF_SETS = 6;
    localparam int IDX_W     = 3;

    // Signed Q.20 calibration coefficients, one set per segment
    localparam int P1_W = 20;
    localparam int P2_W = 24;
    localparam int P3_W = 26;

    localparam logic signed [P1_W-1:0] P1_TAB [0:COEF_SETS-1] = '{
        -20'sd327261, -20'sd48864, -20'sd14628, 20'sd1385, -20'sd1002, -20'sd1002
    };
    localparam logic signed [P2_W-1:0] P2_TAB [0:COEF_SETS-1] = '{
        24'sd8277459, 24'sd3575644, 24'sd2334130, 24'sd1593836, 24'sd1747976, 24'sd1747976
    };
    localparam logic signed [P3_W-1:0] P3_TAB [0:COEF_SETS-1] = '{
        -26'sd18654167, 26'sd1242563, 26'sd12530483, 26'sd22775071, 26'sd14355005,
        26'sd14355005
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREQ,
        ST_QUAD,
        ST_LIN,
        ST_DONE
    } t_state;

    // Operand selection for the shared multiplier
    typedef enum logic [1:0] {
        MUL_RECIP,
        MUL_QUAD,
        MUL_LIN
    } t_mul_sel;

endpackage

`default_nettype wire

>>> src/count_window_to_temperature.sv
// Moving-window pulse count to calibrated temperature, on one shared multiplier.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------------
//   in      | to block  | i_in_valid / o_in_ready | i_gate_count
//   out     | from block| o_out_valid / i_out_ready | o_frequency_q8, o_segment,
//           |           |                         | o_temperature_q8, o_bar_level,
//           |           |                         | o_saturated
//
// For each item the transfer cycle updates the window and its sum, then the
// sequencer uses the single 40x24 multiplier three times (frequency reciprocal, quadratic
// term, linear term via Horner) and loads the output register in a final step.
// The final step waits while a previous result is still held and not taken.
// Synchronous active-low reset clears the history, the sum, the sequencer and out valid.
`default_nettype none

module count_window_to_temperature #(
    parameter int WINDOW_LEN    = cwt_pkg::WINDOW_LEN_DEF,
    parameter int SEGMENT_COUNT = cwt_pkg::SEGMENT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cwt_pkg::COUNT_W-1:0]         i_gate_count,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [cwt_pkg::FQ_W-1:0]            o_frequency_q8,
    output logic [cwt_pkg::SEG_OUT_W-1:0]       o_segment,
    output logic signed [cwt_pkg::TEMP_W-1:0]   o_temperature_q8,
    output logic [cwt_pkg::BAR_W-1:0]           o_bar_level,
    output logic                                o_saturated
);
    import cwt_pkg::*;

    localparam int SUM_W = $clog2(WINDOW_LEN * ((1 << COUNT_W) - 1) + 1);
    localparam int Q_W   = PROD_W - RECIP_SHIFT;

    // Sequencer and window state
    t_state                     r_state, n_state;
    logic [COUNT_W-1:0]         r_hist [0:WINDOW_LEN-1];
    logic [SUM_W-1:0]           r_sum, n_sum;

    // Working registers
    logic [FQ_W-1:0]            r_fq, n_fq;
    logic [SEG_OUT_W-1:0]       r_seg, n_seg;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic signed [MUL_A_W-1:0]  r_acc1, n_acc1;
    logic signed [TEMP_W-1:0]   r_temp, n_temp;
    logic                       r_sat, n_sat;

    // Output register
    logic                       r_out_valid;
    logic [FQ_W-1:0]            r_o_fq;
    logic [SEG_OUT_W-1:0]       r_o_seg;
    logic signed [TEMP_W-1:0]   r_o_temp;
    logic [BAR_W-1:0]           r_o_bar, n_bar;
    logic                       r_o_sat;

    // Control
    logic                       in_ready;
    logic                       out_load;
    logic                       in_xfer;
    t_mul_sel                   mul_sel;

    // Datapath
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic [Q_W-1:0]             q_wide;
    logic [SEG_W-1:0]           seg_raw;
    logic signed [PROD_W-1:0]   acc;
    logic signed [PROD_W-1:0]   t_full;

    assign in_xfer = i_in_valid && in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_FREQ;
            ST_FREQ: n_state = ST_QUAD;
            ST_QUAD: n_state = ST_LIN;
            ST_LIN:  n_state = ST_DONE;
            ST_DONE: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        mul_sel  = MUL_RECIP;
        unique case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_FREQ: mul_sel = MUL_RECIP;
            ST_QUAD: mul_sel = MUL_QUAD;
            ST_LIN:  mul_sel = MUL_LIN;
            ST_DONE: out_load = !r_out_valid || i_out_ready;
            default: in_ready = 1'b0;
        endcase
    end

    // Shared multiplier with operand select
    always_comb begin
        unique case (mul_sel)
            MUL_RECIP: begin
                mul_a = RECIP;
                mul_b = MUL_B_W'(r_sum);
            end
            MUL_QUAD: begin
                mul_a = MUL_A_W'(P1_TAB[r_idx]);
                mul_b = MUL_B_W'(r_fq);
            end
            MUL_LIN: begin
                mul_a = r_acc1;
                mul_b = MUL_B_W'(r_fq);
            end
            default: begin
                mul_a = r_acc1;
                mul_b = MUL_B_W'(r_fq);
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Running sum: add the newest count, drop the oldest
    assign n_sum = r_sum + SUM_W'(i_gate_count) - SUM_W'(r_hist[0]);

    // Frequency: scale, saturate and pick the calibration segment
    always_comb begin
        q_wide  = prod[PROD_W-1:RECIP_SHIFT];
        n_fq    = (q_wide > Q_W'(FREQ_MAX)) ? FQ_W'(FREQ_MAX) : q_wide[FQ_W-1:0];
        seg_raw = '0;
        for (int k = 1; k < SEGMENT_COUNT; k++) begin
            if (n_fq >= FQ_W'(k * SEG_STEP)) seg_raw = seg_raw + SEG_W'(1);
        end
        n_seg = seg_raw[SEG_OUT_W-1:0];
        n_idx = (seg_raw > SEG_W'(COEF_SETS - 1)) ? IDX_W'(COEF_SETS - 1)
                                                 : seg_raw[IDX_W-1:0];
    end

    // Horner first step: p1*f + p2 scaled to Q.28
    assign n_acc1 = prod[MUL_A_W-1:0] + (MUL_A_W'(P2_TAB[r_idx]) <<< 8);

    // Horner second step: add offset, round Q.36 to Q.8 half up, saturate
    always_comb begin
        acc    = prod + (PROD_W'(P3_TAB[r_idx]) <<< 16) + (PROD_W'(1) <<< 27);
        t_full = acc >>> 28;
        n_sat  = 1'b0;
        if (t_full > PROD_W'(TEMP_MAX)) begin
            n_temp = TEMP_W'(TEMP_MAX);
            n_sat  = 1'b1;
        end else if (t_full < PROD_W'(TEMP_MIN)) begin
            n_temp = TEMP_W'(TEMP_MIN);
            n_sat  = 1'b1;
        end else begin
            n_temp = t_full[TEMP_W-1:0];
        end
    end

    // Bar level: temperature over ten degrees, clamped
    always_comb begin
        n_bar = '0;
        if (!r_temp[TEMP_W-1]) begin
            for (int k = 1; k <= BAR_MAX; k++) begin
                if (r_temp >= TEMP_W'(k * BAR_STEP)) n_bar = n_bar + BAR_W'(1);
            end
        end
    end

    // Control state and window history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++) r_hist[i] <= '0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_sum <= n_sum;
                for (int i = 0; i < WINDOW_LEN - 1; i++) r_hist[i] <= r_hist[i + 1];
                r_hist[WINDOW_LEN-1] <= i_gate_count;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FREQ) begin
            r_fq  <= n_fq;
            r_seg <= n_seg;
            r_idx <= n_idx;
        end
        if (r_state == ST_QUAD) r_acc1 <= n_acc1;
        if (r_state == ST_LIN) begin
            r_temp <= n_temp;
            r_sat  <= n_sat;
        end
        if (out_load) begin
            r_o_fq   <= r_fq;
            r_o_seg  <= r_seg;
            r_o_temp <= r_temp;
            r_o_bar  <= n_bar;
            r_o_sat  <= r_sat;
        end
    end

    assign o_in_ready       = in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_frequency_q8   = r_o_fq;
    assign o_segment        = r_o_seg;
    assign o_temperature_q8 = r_o_temp;
    assign o_bar_level      = r_o_bar;
    assign o_saturated      = r_o_sat;

    // A transfer reaches the output load step through the FREQ, QUAD and LIN states
    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##4 (r_state == ST_DONE))
        else $error("sequencer did not reach the output step on time");

    // Saturation leaves the temperature at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_temperature_q8 == TEMP_W'(TEMP_MAX) || o_temperature_q8 == TEMP_W'(TEMP_MIN)))
        else $error("saturated flag without a clipped temperature");

    // Negative temperature shows an empty bar
    a_bar_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_temperature_q8[TEMP_W-1]) |-> (o_bar_level == '0))
        else $error("bar level set for a negative temperature");

    // Low frequency selects the first segment
    a_seg_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_frequency_q8 < FQ_W'(SEG_STEP))) |-> (o_segment == '0))
        else $error("segment does not match frequency");

endmodule

`default_nettype wire
